>>> hdl/dlmc_pkg.sv
// ---------------------------------------------------------------------------
// dlmc_pkg
// shared types and constants of the dynamic light mask cull block
// ---------------------------------------------------------------------------
package dlmc_pkg;

    localparam int COORD_W = 32;
    localparam int MASK_W  = 32;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 5;
    localparam int CMD_W   = 3;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 67;
    localparam int GRID_W  = 34;
    localparam int NRM_FRAC = 14;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 3'd0,
        CMD_FACE  = 3'd1,
        CMD_GRID  = 3'd2,
        CMD_TRI   = 3'd3,
        CMD_OTHER = 3'd4
    } cmd_t;

    typedef enum logic [0:0] {
        REG_NUM_LIGHTS = 1'b0,
        REG_UNUSED     = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
        logic signed [COORD_W-1:0] r;
    } light_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] plane_dist;
        logic                      grid;
    } cull_op_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } cull_tag_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             clear;
        logic [IDX_W-1:0] idx;
    } cull_res_t;

endpackage

>>> hdl/dlmc_if.sv
// ---------------------------------------------------------------------------
// dlmc_if
// valid/ready channels for query items and result items
// ---------------------------------------------------------------------------
interface dlmc_query_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [4:0]         light_index;
    logic [31:0]        light_mask;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic signed [31:0] scalar;

    modport source (
        output valid, command, light_index, light_mask,
        output vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar,
        input  ready
    );
    modport sink (
        input  valid, command, light_index, light_mask,
        input  vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar,
        output ready
    );
endinterface

interface dlmc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_mask;
    logic        any_lit;

    modport source (
        output valid, result_mask, any_lit,
        input  ready
    );
    modport sink (
        input  valid, result_mask, any_lit,
        output ready
    );
endinterface

>>> hdl/dlmc_apb_regs.sv
// ---------------------------------------------------------------------------
// dlmc_apb_regs
// apb register file holding the active light count
// ---------------------------------------------------------------------------
module dlmc_apb_regs
    import dlmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CNT_W-1:0]  num_lights
);

    logic [CNT_W-1:0] num_lights_reg;
    logic [CNT_W-1:0] num_lights_next;
    reg_idx_t         reg_sel;
    logic             wr_en;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        num_lights_next = num_lights_reg;
        if (wr_en && reg_sel == REG_NUM_LIGHTS)
        begin
            num_lights_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lights_reg <= '0;
        end
        else
        begin
            num_lights_reg <= num_lights_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NUM_LIGHTS: prdata = {{(APB_DW-CNT_W){1'b0}}, num_lights_reg};
            default:        prdata = '0;
        endcase
    end

    assign num_lights = num_lights_reg;

endmodule

>>> hdl/dlmc_light_ram.sv
// ---------------------------------------------------------------------------
// dlmc_light_ram
// light table memory with per-entry valid bits, registered read
// ---------------------------------------------------------------------------
module dlmc_light_ram
    import dlmc_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  light_t        wdata,
    input  logic [AW-1:0] raddr,
    output light_t        rdata
);

    light_t             mem [DEPTH];
    logic [DEPTH-1:0]   vld_reg;
    light_t             rd_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    // entries never loaded read as zero
    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

>>> hdl/dlmc_cull_unit.sv
// ---------------------------------------------------------------------------
// dlmc_cull_unit
// two-stage sphere/plane and cube/box test, one light per cycle
// ---------------------------------------------------------------------------
module dlmc_cull_unit
    import dlmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cull_tag_t tag_in,
    input  light_t    light,
    input  cull_op_t  op,
    output cull_res_t res
);

    cull_tag_t                 tag_a_reg;
    cull_tag_t                 tag_b_reg;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic signed [PROD_W-1:0]  pz_reg;
    logic signed [PROD_W-1:0]  px_next;
    logic signed [PROD_W-1:0]  py_next;
    logic signed [PROD_W-1:0]  pz_next;
    logic signed [COORD_W-1:0] r_reg;
    logic signed [GRID_W-1:0]  lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [GRID_W-1:0]  hi_x_reg, hi_y_reg, hi_z_reg;
    logic signed [SUM_W-1:0]   d_reg;
    logic signed [SUM_W-1:0]   d_next;
    logic signed [SUM_W-1:0]   rs_reg;
    logic signed [SUM_W-1:0]   rs_next;
    logic                      gmiss_reg;
    logic                      gmiss_next;
    logic                      face_miss;

    // stage a: products and cube extents
    assign px_next = light.ox * op.ax;
    assign py_next = light.oy * op.ay;
    assign pz_next = light.oz * op.az;

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        r_reg    <= light.r;
        lo_x_reg <= GRID_W'(light.ox) - GRID_W'(light.r);
        lo_y_reg <= GRID_W'(light.oy) - GRID_W'(light.r);
        lo_z_reg <= GRID_W'(light.oz) - GRID_W'(light.r);
        hi_x_reg <= GRID_W'(light.ox) + GRID_W'(light.r);
        hi_y_reg <= GRID_W'(light.oy) + GRID_W'(light.r);
        hi_z_reg <= GRID_W'(light.oz) + GRID_W'(light.r);
    end

    // stage b: plane distance sum and box compares
    assign d_next = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg)
                  - (SUM_W'(op.plane_dist) <<< NRM_FRAC);
    assign rs_next = SUM_W'(r_reg) <<< NRM_FRAC;

    always_comb
    begin
        gmiss_next = (lo_x_reg > GRID_W'(op.bx)) || (hi_x_reg < GRID_W'(op.ax))
                  || (lo_y_reg > GRID_W'(op.by)) || (hi_y_reg < GRID_W'(op.ay))
                  || (lo_z_reg > GRID_W'(op.bz)) || (hi_z_reg < GRID_W'(op.az));
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        rs_reg    <= rs_next;
        gmiss_reg <= gmiss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    // negative radius makes the band empty, so the light always misses
    assign face_miss = (d_reg > rs_reg) || (d_reg < -rs_reg);

    always_comb
    begin
        res.valid = tag_b_reg.valid;
        res.last  = tag_b_reg.last;
        res.idx   = tag_b_reg.idx;
        res.clear = tag_b_reg.valid && (op.grid ? gmiss_reg : face_miss);
    end

endmodule

>>> hdl/dynamic_light_mask_cull.sv
// ---------------------------------------------------------------------------
// dynamic_light_mask_cull
// light table with face and grid mask culling behind valid/ready channels
// ---------------------------------------------------------------------------
// a load writes the light table when accepted; a face/grid query scans n lights, one
// table read per light, through the cull unit into the result register; other queries
// go straight to the result register, and only one query is in flight at a time
// reset: light table reads as zero and num_lights is 0, no clearing pass
// the next item is taken while a result waits in the output register
module dynamic_light_mask_cull
    import dlmc_pkg::*;
#(
    parameter int MAX_LIGHTS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    dlmc_query_if.sink        query,
    dlmc_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    cull_op_t          op_reg, op_next;
    cull_tag_t         tag_rd_reg, tag_issue;
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_any_reg;
    logic              out_load;
    logic              issue;
    logic              q_acc;
    logic              zero_nrm;
    logic              slot_ok;
    logic              ram_we;
    logic [CNT_W-1:0]  num_lights;
    logic [CNT_W-1:0]  n_lights;
    logic [CNT_W-1:0]  last_idx;
    logic [MASK_W-1:0] clr_vec;
    light_t            wr_light;
    light_t            rd_light;
    cull_res_t         cres;

    dlmc_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .num_lights (num_lights)
    );

    assign n_lights = (num_lights > CNT_W'(MAX_LIGHTS)) ? CNT_W'(MAX_LIGHTS) : num_lights;
    assign last_idx = n_lights - CNT_W'(1);

    assign query.ready = (state_reg == ST_IDLE);
    assign q_acc       = query.valid && query.ready;
    assign zero_nrm    = (query.vec_a_x == '0) && (query.vec_a_y == '0)
                      && (query.vec_a_z == '0);
    assign slot_ok     = ({1'b0, query.light_index} < CNT_W'(MAX_LIGHTS));
    assign ram_we      = q_acc && (query.command == CMD_LOAD) && slot_ok;

    always_comb
    begin
        wr_light.ox = query.vec_a_x;
        wr_light.oy = query.vec_a_y;
        wr_light.oz = query.vec_a_z;
        wr_light.r  = query.scalar;
    end

    dlmc_light_ram #(
        .DEPTH (MAX_LIGHTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (query.light_index[AW-1:0]),
        .wdata (wr_light),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_light)
    );

    always_comb
    begin
        tag_issue.valid = issue;
        tag_issue.last  = (cnt_reg == last_idx);
        tag_issue.idx   = cnt_reg[IDX_W-1:0];
    end

    dlmc_cull_unit u_cull (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag_rd_reg),
        .light  (rd_light),
        .op     (op_reg),
        .res    (cres)
    );

    assign clr_vec = MASK_W'(1) << cres.idx;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mask_next  = mask_reg;
        op_next    = op_reg;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_acc)
                begin
                    cnt_next           = '0;
                    op_next.ax         = query.vec_a_x;
                    op_next.ay         = query.vec_a_y;
                    op_next.az         = query.vec_a_z;
                    op_next.bx         = query.vec_b_x;
                    op_next.by         = query.vec_b_y;
                    op_next.bz         = query.vec_b_z;
                    op_next.plane_dist = query.scalar;
                    op_next.grid       = (query.command == CMD_GRID);
                    mask_next          = query.light_mask;
                    case (query.command)
                        CMD_LOAD:
                        begin
                            state_next = ST_IDLE;
                        end
                        CMD_FACE:
                        begin
                            if (zero_nrm || n_lights == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_GRID:
                        begin
                            if (n_lights == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_TRI:
                        begin
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            mask_next  = '0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                issue    = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cres.valid && cres.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cres.clear)
        begin
            mask_next = mask_reg & ~clr_vec;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tag_rd_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tag_rd_reg    <= tag_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        op_reg   <= op_next;
        if (out_load)
        begin
            out_mask_reg <= mask_reg;
            out_any_reg  <= |mask_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_mask = out_mask_reg;
    assign result.any_lit     = out_any_reg;

`ifndef ASSERT_OFF
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("table write outside idle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg < n_lights))
        else $error("scan index beyond light count");

    a_cull_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cres.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("cull result outside scan");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || result.ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished query not moved to output register");

    a_any_lit_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_any_reg == (out_mask_reg != '0)))
        else $error("any_lit disagrees with mask");
`endif

endmodule
